FILE: rtl/core/rpta_pkg.sv
package rpta_pkg;

    localparam int ID_BITS    = 20;
    localparam int SUM_W      = 32;
    localparam int WT_W       = 17;
    localparam int RESULT_CAP = 32;
    localparam logic [WT_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [1:0] CFG_CLASS_MODE  = 2'd0;
    localparam logic [1:0] CFG_MIN_WEIGHT  = 2'd1;
    localparam logic [1:0] CFG_EXP_INSERT  = 2'd2;

    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    typedef struct packed {
        logic                    occ;
        logic [ID_BITS-1:0]      key;
        logic signed [SUM_W-1:0] sum;
        logic                    keep;
        logic [WT_W-1:0]         wt;
    } t_cell_data;

    typedef struct packed {
        logic hit;
        logic ins;
        logic rot;
        logic clr;
    } t_cell_ctl;

endpackage

FILE: rtl/core/read_pair_transcript_assignment_top.sv
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+---------------------------------
// request   | i_opcode .. i_read_tag              | i_start high while o_busy low
// result    | o_tag_out .. o_last                 | o_valid for one cycle, no stall
// config    | i_cfg_we, i_cfg_idx, i_cfg_data     | write when i_cfg_we is high
// A hit request is handled in the idle state; the cells match the key in parallel.
// A close request rotates the cell ring once per pass: in class mode a total pass, the
// threshold steps, a keep pass, a division pass and a scan pass per result; best mode
// uses a single pass. An empty class record ends after the total pass, or after the
// keep pass when every candidate is dropped. Divisions share one divider; a clear
// state ends a close. Reset is synchronous, active low, and empties the table.
module read_pair_transcript_assignment_top
    import rpta_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_opcode,
    input  logic [ID_BITS-1:0]   i_transcript_id,
    input  logic signed [31:0]   i_score,
    input  logic [31:0]          i_insert_size,
    input  logic                 i_junction_seen,
    input  logic [15:0]          i_read_tag,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_valid,
    output logic [15:0]          o_tag_out,
    output logic [ID_BITS-1:0]   o_member_id,
    output logic [WT_W-1:0]      o_weight,
    output logic                 o_member_valid,
    output logic [31:0]          o_insert_out,
    output logic                 o_junction_flag,
    output logic                 o_overflow,
    output logic                 o_last
);

    localparam int PW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int NW  = (CW > 6) ? CW : 6;
    localparam int TW  = 32 + PW;
    localparam int HW  = TW - 19;
    localparam int THW = WT_W + TW;
    localparam int RW  = TW + WT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_TOTAL, S_THR_LO, S_THR_HI, S_KEPT, S_DHEAD, S_DIV, S_SCAN, S_BEST, S_CLR
    } t_state;

    t_state              r_state;
    logic                r_class;
    logic [WT_W-1:0]     r_minw;
    logic [31:0]         r_exp;
    logic [CW-1:0]       r_count;
    logic                r_ovf;
    logic [PW-1:0]       r_pos;
    logic [15:0]         r_tag;
    logic [31:0]         r_ins;
    logic                r_junc;
    logic [TW-1:0]       r_total;
    logic [35:0]         r_thr_lo;
    logic [THW-1:0]      r_thr;
    logic [TW-1:0]       r_kept;
    logic [CW-1:0]       r_n;
    logic [NW-1:0]       r_emitted;
    logic [RW-1:0]       r_rem;
    logic [WT_W-1:0]     r_q;
    logic [4:0]          r_bit;
    logic                r_found;
    logic [PW-1:0]       r_best_pos;
    logic [ID_BITS-1:0]  r_best_key;
    logic [WT_W-1:0]     r_best_wt;
    logic signed [31:0]  r_best_sum;
    logic                r_clr_en;
    logic [PW-1:0]       r_clr_pos;

    t_cell_data          w_cell [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_match;
    t_cell_ctl           w_ctl;
    t_cell_data          w_head;
    t_cell_data          w_rot_in;
    logic                w_pos_end;
    logic [PW-1:0]       w_pos_nxt;
    logic                w_pos_sum;
    logic                w_keep_ok;
    logic                w_eff;
    logic [RW-1:0]       w_dvs;
    logic                w_ge;
    logic [WT_W-1:0]     w_q_next;
    logic [32:0]         w_lim3;
    logic [NW-1:0]       w_lim;
    logic                w_better;
    logic [WT_W+HW-1:0]  w_thr_hi;
    logic                w_emit;

    assign w_head    = w_cell[0];
    assign w_pos_end = (r_pos == PW'(MAX_ENTRIES - 1));
    assign w_pos_nxt = w_pos_end ? '0 : r_pos + 1'b1;
    assign w_pos_sum = w_head.occ && !w_head.sum[31] && (w_head.sum != 32'sd0);
    assign w_keep_ok = w_pos_sum &&
                       !(THW'({w_head.sum[30:0], 16'd0}) < r_thr);
    assign w_eff     = w_head.keep && !(r_clr_en && (r_pos == r_clr_pos));
    assign w_dvs     = RW'(r_kept) << r_bit;
    assign w_ge      = (r_rem >= w_dvs);
    assign w_q_next  = r_q | (w_ge ? (WT_W'(1) << r_bit) : '0);
    assign w_lim3    = {1'b0, r_exp} + {2'b0, r_exp[31:1]};
    assign w_lim     = (NW'(r_n) < NW'(RESULT_CAP)) ? NW'(r_n) : NW'(RESULT_CAP);
    assign w_better  = w_eff && (!r_found || (w_head.wt > r_best_wt));
    assign w_thr_hi  = r_minw * r_total[TW-1:19];
    assign w_emit    = ((r_state == S_THR_HI) && (r_total == '0)) ||
                       ((r_state == S_KEPT) && w_pos_end && (r_n == '0) && !w_keep_ok) ||
                       (((r_state == S_SCAN) || (r_state == S_BEST)) && w_pos_end);

    always_comb begin
        w_ctl.hit = (r_state == S_IDLE) && i_start && (i_opcode == OP_HIT);
        w_ctl.ins = w_ctl.hit && !(|w_match);
        w_ctl.clr = (r_state == S_CLR);
        w_ctl.rot = (r_state == S_TOTAL) || (r_state == S_KEPT) || (r_state == S_SCAN) ||
                    (r_state == S_BEST) || ((r_state == S_DHEAD) && !w_head.keep) ||
                    ((r_state == S_DIV) && (r_bit == 5'd0));
        w_rot_in = w_head;
        case (r_state)
            S_KEPT:  w_rot_in.keep = w_keep_ok;
            S_DIV:   w_rot_in.wt   = w_q_next;
            S_SCAN:  w_rot_in.keep = w_eff;
            default: w_rot_in = w_head;
        endcase
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        rpta_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (i_transcript_id),
            .i_score    (i_score),
            .i_prev_occ ((g == 0) ? 1'b1 : w_cell[(g == 0) ? 0 : g-1].occ),
            .i_next     ((g == MAX_ENTRIES-1) ? w_rot_in :
                         w_cell[(g == MAX_ENTRIES-1) ? g : g+1]),
            .o_data     (w_cell[g]),
            .o_match    (w_match[g])
        );
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_class   <= 1'b1;
            r_minw    <= '0;
            r_exp     <= '0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            o_valid   <= 1'b0;
            r_clr_en  <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            o_valid <= w_emit;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLASS_MODE: r_class <= i_cfg_data[0];
                    CFG_MIN_WEIGHT: r_minw  <= i_cfg_data[WT_W-1:0];
                    CFG_EXP_INSERT: r_exp   <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_ctl.hit && !(|w_match)) begin
                        if (r_count == CW'(MAX_ENTRIES)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    if (i_start && (i_opcode == OP_CLOSE)) begin
                        r_tag    <= i_read_tag;
                        r_ins    <= i_insert_size;
                        r_junc   <= i_junction_seen ||
                                    ((r_exp != 32'd0) && ({1'b0, i_insert_size} > w_lim3));
                        r_pos    <= '0;
                        r_total  <= '0;
                        r_found  <= 1'b0;
                        r_state  <= r_class ? S_TOTAL : S_BEST;
                    end
                end
                S_TOTAL: begin
                    if (w_pos_sum) begin
                        r_total <= r_total + TW'(w_head.sum[30:0]);
                    end
                    r_pos <= w_pos_nxt;
                    if (w_pos_end) begin
                        r_state <= S_THR_LO;
                    end
                end
                S_THR_LO: begin
                    r_thr_lo <= r_minw * r_total[18:0];
                    r_state  <= S_THR_HI;
                end
                S_THR_HI: begin
                    r_thr  <= (THW'(w_thr_hi) << 19) + THW'(r_thr_lo);
                    r_kept <= '0;
                    r_n    <= '0;
                    r_pos  <= '0;
                    if (r_total == '0) begin
                        o_member_valid <= 1'b0;
                        o_member_id    <= '0;
                        o_weight       <= '0;
                        o_last         <= 1'b1;
                        r_state        <= S_CLR;
                    end else begin
                        r_state <= S_KEPT;
                    end
                end
                S_KEPT: begin
                    if (w_keep_ok) begin
                        r_kept <= r_kept + TW'(w_head.sum[30:0]);
                        r_n    <= r_n + 1'b1;
                    end
                    r_pos <= w_pos_nxt;
                    if (w_pos_end) begin
                        if ((r_n == '0) && !w_keep_ok) begin
                            o_member_valid <= 1'b0;
                            o_member_id    <= '0;
                            o_weight       <= '0;
                            o_last         <= 1'b1;
                            r_state        <= S_CLR;
                        end else begin
                            r_state <= S_DHEAD;
                        end
                    end
                end
                S_DHEAD: begin
                    if (w_head.keep) begin
                        r_rem   <= RW'({w_head.sum[30:0], 16'd0}) + RW'(r_kept >> 1);
                        r_q     <= '0;
                        r_bit   <= 5'd16;
                        r_state <= S_DIV;
                    end else begin
                        r_pos <= w_pos_nxt;
                        if (w_pos_end) begin
                            r_state   <= S_SCAN;
                            r_emitted <= '0;
                            r_clr_en  <= 1'b0;
                            r_found   <= 1'b0;
                        end
                    end
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - w_dvs;
                    end
                    r_q   <= w_q_next;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 5'd0) begin
                        r_pos <= w_pos_nxt;
                        if (w_pos_end) begin
                            r_state   <= S_SCAN;
                            r_emitted <= '0;
                            r_clr_en  <= 1'b0;
                            r_found   <= 1'b0;
                        end else begin
                            r_state <= S_DHEAD;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_better) begin
                        r_best_pos <= r_pos;
                        r_best_key <= w_head.key;
                        r_best_wt  <= w_head.wt;
                    end
                    r_pos <= w_pos_nxt;
                    if (w_pos_end) begin
                        r_found        <= 1'b0;
                        r_clr_en       <= 1'b1;
                        r_clr_pos      <= w_better ? r_pos : r_best_pos;
                        r_emitted      <= r_emitted + 1'b1;
                        o_member_valid <= 1'b1;
                        o_member_id    <= w_better ? w_head.key : r_best_key;
                        o_weight       <= w_better ? w_head.wt : r_best_wt;
                        o_last         <= (r_emitted + 1'b1 == w_lim);
                        if (r_emitted + 1'b1 == w_lim) begin
                            r_state <= S_CLR;
                        end
                    end else if (w_better) begin
                        r_found <= 1'b1;
                    end
                end
                S_BEST: begin
                    if (w_head.occ && (!r_found || (w_head.sum > r_best_sum))) begin
                        r_found    <= 1'b1;
                        r_best_sum <= w_head.sum;
                        r_best_key <= w_head.key;
                    end
                    r_pos <= w_pos_nxt;
                    if (w_pos_end) begin
                        o_last  <= 1'b1;
                        if (r_found || w_head.occ) begin
                            o_member_valid <= 1'b1;
                            o_weight       <= ONE_Q16;
                            o_member_id    <= (w_head.occ &&
                                               (!r_found || (w_head.sum > r_best_sum))) ?
                                              w_head.key : r_best_key;
                        end else begin
                            o_member_valid <= 1'b0;
                            o_weight       <= '0;
                            o_member_id    <= '0;
                        end
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tag_out       = r_tag;
    assign o_insert_out    = r_ins;
    assign o_junction_flag = r_junc;
    assign o_overflow      = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES)) else $error("Entry count beyond table size.");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_member_valid |-> o_last) else $error("Empty record not final.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> (r_state == S_CLR) ##1 (r_count == '0) && !r_ovf)
        else $error("Table not cleared after record.");

endmodule

FILE: rtl/core/rpta_cell.sv
module rpta_cell
    import rpta_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic [ID_BITS-1:0]      i_key,
    input  logic signed [SUM_W-1:0] i_score,
    input  logic                    i_prev_occ,
    input  t_cell_data              i_next,
    output t_cell_data              o_data,
    output logic                    o_match
);

    logic                    r_occ;
    logic [ID_BITS-1:0]      r_key;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_keep;
    logic [WT_W-1:0]         r_wt;
    logic signed [SUM_W:0]   w_add;
    logic signed [SUM_W-1:0] w_sat;
    logic                    w_take;

    assign o_match = r_occ && (r_key == i_key);
    assign w_take  = i_ctl.ins && !r_occ && i_prev_occ;
    assign w_add   = {r_sum[SUM_W-1], r_sum} + {i_score[SUM_W-1], i_score};

    always_comb begin
        if (w_add[SUM_W] != w_add[SUM_W-1]) begin
            w_sat = w_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sat = w_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.clr) begin
            r_occ <= 1'b0;
        end else if (i_ctl.rot) begin
            r_occ <= i_next.occ;
        end else if (w_take) begin
            r_occ <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            r_key  <= i_next.key;
            r_sum  <= i_next.sum;
            r_keep <= i_next.keep;
            r_wt   <= i_next.wt;
        end else if (i_ctl.hit && o_match) begin
            r_sum <= w_sat;
        end else if (w_take) begin
            r_key <= i_key;
            r_sum <= i_score;
        end
    end

    assign o_data = '{occ: r_occ, key: r_key, sum: r_sum, keep: r_keep, wt: r_wt};

endmodule

FILE: sim/read_pair_transcript_assignment_top_tb.sv
`timescale 1ns / 100ps

module read_pair_transcript_assignment_top_tb;
    import rpta_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef longint unsigned t_u64;

    typedef struct {
        logic [15:0]        tag;
        logic [ID_BITS-1:0] id;
        logic [WT_W-1:0]    wt;
        logic               mv;
        logic [31:0]        ins;
        logic               junc;
        logic               ovf;
        logic               last;
    } t_member;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic                 i_opcode;
    logic [ID_BITS-1:0]   i_transcript_id;
    logic signed [31:0]   i_score;
    logic [31:0]          i_insert_size;
    logic                 i_junction_seen;
    logic [15:0]          i_read_tag;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_idx;
    logic [31:0]          i_cfg_data;
    logic                 o_valid;
    logic [15:0]          o_tag_out;
    logic [ID_BITS-1:0]   o_member_id;
    logic [WT_W-1:0]      o_weight;
    logic                 o_member_valid;
    logic [31:0]          o_insert_out;
    logic                 o_junction_flag;
    logic                 o_overflow;
    logic                 o_last;

    read_pair_transcript_assignment_top dut (.*);

    t_member            expected_members[$];
    logic [ID_BITS-1:0] hit_key[TABLE_DEPTH];
    longint             hit_sum[TABLE_DEPTH];
    int                 hit_count;
    bit                 table_overflow;
    bit                 class_mode;
    t_u64               min_weight;
    t_u64               expected_insert;
    int                 errors;
    int                 requests_sent;
    bit                 gaps_on;
    longint             cycles;
    logic [ID_BITS-1:0] id_pool[8];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic merge_hit(input logic [ID_BITS-1:0] id, input logic signed [31:0] sc);
        longint t;
        for (int i = 0; i < hit_count; i++) begin
            if (hit_key[i] == id) begin
                t = hit_sum[i] + longint'(sc);
                if (t > 64'sd2147483647) t = 64'sd2147483647;
                if (t < -64'sd2147483648) t = -64'sd2147483648;
                hit_sum[i] = t;
                return;
            end
        end
        if (hit_count < TABLE_DEPTH) begin
            hit_key[hit_count] = id;
            hit_sum[hit_count] = longint'(sc);
            hit_count++;
        end else begin
            table_overflow = 1'b1;
        end
    endtask

    task automatic assign_members(input logic [31:0] ins, input logic junc_in,
                                  input logic [15:0] tag);
        t_u64            total;
        t_u64            kept;
        t_u64            s;
        t_u64            cw;
        t_u64            wts[TABLE_DEPTH];
        int              sel[TABLE_DEPTH];
        int              n;
        int              ci;
        int              m;
        int              b;
        logic            junc;
        t_member         r;
        n = 0;
        junc = junc_in;
        if (expected_insert != 0 && t_u64'(ins) > (expected_insert * 3) / 2)
            junc = 1'b1;
        if (class_mode) begin
            total = 0;
            kept = 0;
            for (int i = 0; i < hit_count; i++)
                if (hit_sum[i] > 0) total += t_u64'(hit_sum[i]);
            if (total > 0) begin
                for (int i = 0; i < hit_count; i++) begin
                    if (hit_sum[i] <= 0) continue;
                    s = t_u64'(hit_sum[i]);
                    if (s * 65536 < min_weight * total) continue;
                    sel[n] = i;
                    n++;
                    kept += s;
                end
                for (int j = 0; j < n; j++)
                    wts[j] = (t_u64'(hit_sum[sel[j]]) * 65536 + kept / 2) / kept;
                for (int j = 1; j < n; j++) begin
                    ci = sel[j];
                    cw = wts[j];
                    m = j - 1;
                    while (m >= 0 && wts[m] < cw) begin
                        sel[m + 1] = sel[m];
                        wts[m + 1] = wts[m];
                        m--;
                    end
                    sel[m + 1] = ci;
                    wts[m + 1] = cw;
                end
            end
        end else if (hit_count > 0) begin
            b = 0;
            for (int i = 1; i < hit_count; i++)
                if (hit_sum[i] > hit_sum[b]) b = i;
            sel[0] = b;
            wts[0] = 65536;
            n = 1;
        end
        r.tag = tag;
        r.ins = ins;
        r.junc = junc;
        r.ovf = table_overflow;
        if (n == 0) begin
            r.id = '0;
            r.wt = '0;
            r.mv = 1'b0;
            r.last = 1'b1;
            expected_members = {expected_members, r};
        end else begin
            if (n > RESULT_CAP) n = RESULT_CAP;
            for (int k = 0; k < n; k++) begin
                r.id = hit_key[sel[k]];
                r.wt = wts[k][WT_W-1:0];
                r.mv = 1'b1;
                r.last = (k == n - 1);
                expected_members = {expected_members, r};
            end
        end
        hit_count = 0;
        table_overflow = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_member e;
        if (i_rst_n && o_valid) begin
            if (expected_members.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tag %0h id %0h",
                         $time, o_tag_out, o_member_id);
                errors++;
            end else begin
                e = expected_members.pop_front();
                check_field("tag_out", e.tag, o_tag_out);
                check_field("member_id", e.id, o_member_id);
                check_field("weight", e.wt, o_weight);
                check_field("member_valid", e.mv, o_member_valid);
                check_field("insert_out", e.ins, o_insert_out);
                check_field("junction_flag", e.junc, o_junction_flag);
                check_field("overflow", e.ovf, o_overflow);
                check_field("last", e.last, o_last);
            end
        end
    end

    task automatic send_request(input logic op, input logic [ID_BITS-1:0] id,
                                input logic signed [31:0] sc, input logic [31:0] ins,
                                input logic junc, input logic [15:0] tag);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        repeat (gap) @(negedge i_clk);
        i_opcode = op;
        i_transcript_id = id;
        i_score = sc;
        i_insert_size = ins;
        i_junction_seen = junc;
        i_read_tag = tag;
        i_start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        if (op == OP_HIT) merge_hit(id, sc);
        else assign_members(ins, junc, tag);
        requests_sent++;
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic send_hit(input logic [ID_BITS-1:0] id, input logic signed [31:0] sc);
        send_request(OP_HIT, id, sc, 32'($urandom), 1'($urandom_range(0, 1)),
                     16'($urandom));
    endtask

    task automatic send_close(input logic [31:0] ins, input logic junc, input logic [15:0] tag);
        send_request(OP_CLOSE, ID_BITS'($urandom), 32'($urandom), ins, junc, tag);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (expected_members.size() != 0 || o_busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_CLASS_MODE: class_mode = data[0];
            CFG_MIN_WEIGHT: min_weight = data[WT_W-1:0];
            CFG_EXP_INSERT: expected_insert = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_directed();
        send_close(32'd0, 1'b0, 16'h0000);
        send_hit('0, 32'sd65536);
        send_close(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_hit({ID_BITS{1'b1}}, 32'sh7FFF_FFFF);
        send_hit({ID_BITS{1'b1}}, 32'sh7FFF_FFFF);
        send_hit(20'h5_5555, 32'sh0001_0000);
        send_close(32'd300, 1'b0, 16'h1234);
        send_hit(20'hA_AAAA, -32'sh8000_0000);
        send_hit(20'hA_AAAA, -32'sh0000_0001);
        send_hit(20'h0_0001, -32'sd5);
        send_close(32'd1, 1'b0, 16'h00FF);
        send_hit(20'd7, 32'sd1000);
        send_hit(20'd8, 32'sd1000);
        send_hit(20'd9, 32'sd500);
        send_hit(20'd10, 32'sd3000);
        send_close(32'd77, 1'b1, 16'hAAAA);
        send_hit(20'd3, 32'sd0);
        send_close(32'd5, 1'b0, 16'h5555);
    endtask

    task automatic test_table_overflow();
        for (int i = 0; i < TABLE_DEPTH + 3; i++) send_hit(ID_BITS'(32'h100 + i), 32'sd100 + i);
        send_hit(20'h100, 32'sd50000);
        send_close(32'($urandom), 1'b0, 16'($urandom));
        send_hit(20'h200, 32'sd10);
        send_close(32'($urandom), 1'b0, 16'($urandom));
    endtask

    task automatic test_config();
        write_reg(CFG_EXP_INSERT, 32'd1000);
        send_hit(20'd1, 32'sd100);
        send_close(32'd1500, 1'b0, 16'd1);
        send_hit(20'd1, 32'sd100);
        send_close(32'd1501, 1'b0, 16'd2);
        write_reg(CFG_EXP_INSERT, 32'hFFFF_FFFF);
        send_close(32'hFFFF_FFFF, 1'b0, 16'd3);
        write_reg(CFG_MIN_WEIGHT, 32'd65536);
        send_hit(20'd1, 32'sd100);
        send_close(32'd0, 1'b0, 16'd4);
        send_hit(20'd1, 32'sd100);
        send_hit(20'd2, 32'sd300);
        send_close(32'd0, 1'b0, 16'd5);
        write_reg(CFG_MIN_WEIGHT, 32'd131071);
        send_hit(20'd1, 32'sd100);
        send_close(32'd0, 1'b0, 16'd6);
        write_reg(CFG_MIN_WEIGHT, 32'd20000);
        for (int i = 0; i < 6; i++) send_hit(ID_BITS'(20 + i), 32'sd1000 * (i + 1));
        send_close(32'd0, 1'b0, 16'd7);
        write_reg(CFG_CLASS_MODE, 32'd0);
        send_hit(20'd1, -32'sd50);
        send_hit(20'd2, -32'sd20);
        send_hit(20'd3, -32'sd20);
        send_close(32'd0, 1'b0, 16'd8);
        send_close(32'd0, 1'b0, 16'd9);
        write_reg(CFG_EXP_INSERT, 32'd0);
        write_reg(CFG_MIN_WEIGHT, 32'd0);
        write_reg(CFG_CLASS_MODE, 32'd1);
    endtask

    task automatic random_pair();
        int              kind;
        int              nhits;
        logic signed [31:0] sc;
        kind = $urandom_range(0, 9);
        nhits = kind < 8 ? $urandom_range(1, 6) : (kind == 8 ? $urandom_range(30, 36) : 0);
        for (int i = 0; i < nhits; i++) begin
            case ($urandom_range(0, 9))
                0, 1: sc = $urandom;
                2: sc = -$signed({1'b0, 31'($urandom_range(0, 100000))});
                default: sc = $urandom_range(1, 200000);
            endcase
            if (kind == 8) send_hit(ID_BITS'($urandom), sc);
            else send_hit(id_pool[$urandom_range(0, 7)], sc);
        end
        send_close($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2500),
                   1'($urandom_range(0, 1)), 16'($urandom));
    endtask

    task automatic test_random();
        while (requests_sent < 130) begin
            foreach (id_pool[i]) id_pool[i] = ID_BITS'($urandom);
            random_pair();
            if ($urandom_range(0, 7) == 0) drain();
            if ($urandom_range(0, 9) == 0) gaps_on = ~gaps_on;
            if ($urandom_range(0, 12) == 0) begin
                write_reg(CFG_CLASS_MODE, $urandom_range(0, 3) != 0 ? 32'd1 : 32'd0);
                write_reg(CFG_MIN_WEIGHT, $urandom_range(0, 1) ? 0 : $urandom_range(0, 131071));
                write_reg(CFG_EXP_INSERT, $urandom_range(0, 1) ? 0 : $urandom_range(0, 2000));
            end
        end
    endtask

    initial begin
        cycles = 0;
        errors = 0;
        requests_sent = 0;
        gaps_on = 1'b1;
        hit_count = 0;
        table_overflow = 1'b0;
        class_mode = 1'b1;
        min_weight = 0;
        expected_insert = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_opcode = OP_HIT;
        i_transcript_id = '0;
        i_score = '0;
        i_insert_size = '0;
        i_junction_seen = 1'b0;
        i_read_tag = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CLASS_MODE;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_table_overflow();
        test_config();
        test_random();
        drain();
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rpta_pkg.sv
rtl/core/rpta_cell.sv
rtl/core/read_pair_transcript_assignment_top.sv
sim/read_pair_transcript_assignment_top_tb.sv
